// ----- hdl/tti_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tti_pkg
// Shared types, sizes and helpers of the trilinear table interpolator.
// ----------------------------------------------------------------------------
package tti_pkg;

    localparam int X_POINTS   = 128;
    localparam int Y_POINTS   = 128;
    localparam int Z_POINTS   = 32;
    localparam int XI_W       = $clog2(X_POINTS);
    localparam int YI_W       = $clog2(Y_POINTS);
    localparam int ZI_W       = $clog2(Z_POINTS);
    localparam int X_BASE     = 0;
    localparam int Y_BASE     = X_POINTS;
    localparam int Z_BASE     = X_POINTS + Y_POINTS;
    localparam int PT_DEPTH   = Z_BASE + Z_POINTS;
    localparam int PT_AW      = $clog2(PT_DEPTH);
    localparam int GRID_AW    = XI_W + YI_W + ZI_W;
    localparam int GRID_DEPTH = 2 ** GRID_AW;
    localparam int CNT_W      = 8;
    localparam int ZCNT_W     = 6;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int NUM_W      = 66;
    localparam int DEN_W      = 33;
    localparam int DIV_CW     = $clog2(NUM_W);

    localparam logic [2:0] REQ_WX    = 3'd0;
    localparam logic [2:0] REQ_WY    = 3'd1;
    localparam logic [2:0] REQ_WZ    = 3'd2;
    localparam logic [2:0] REQ_WGRID = 3'd3;
    localparam logic [2:0] REQ_QUERY = 3'd4;

    localparam logic [1:0] CFG_X = 2'd0;
    localparam logic [1:0] CFG_Y = 2'd1;
    localparam logic [1:0] CFG_Z = 2'd2;

    typedef enum logic [1:0] {
        OP_WPT,
        OP_WGRID,
        OP_QUERY
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [PT_AW-1:0]     pt_addr;
        logic [GRID_AW-1:0]   grid_addr;
        logic signed [31:0]   value;
        logic signed [31:0]   qx;
        logic signed [31:0]   qy;
        logic signed [31:0]   qz;
    } t_item;

    typedef struct packed {
        logic [CNT_W-1:0] x_n;
        logic [CNT_W-1:0] y_n;
        logic [CNT_W-1:0] z_n;
    } t_counts;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SRD0,
        B_SCHK0,
        B_SCHKN,
        B_SCAN,
        B_GISS,
        B_GCAP,
        B_LCHK,
        B_LHI,
        B_LM0,
        B_LM1,
        B_LM2,
        B_LDIV,
        B_LWAIT,
        B_LWB,
        B_DONE
    } t_bstate;

    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] r,
                                                   input int size);
        logic [CNT_W-1:0] res;
        if (r == '0)
            res = CNT_W'(1);
        else if (int'(r) > size)
            res = CNT_W'(size);
        else
            res = r;
        return res;
    endfunction

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] res;
        if (v[32] != v[31])
            res = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else
            res = v[31:0];
        return res;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/tti_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tti_front
// Input stage: accepts transactions, decodes the request type, drops unknown
// codes and forms memory addresses before handing items to the queue.
// ----------------------------------------------------------------------------
module tti_front
    import tti_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [2:0]          i_req_type,
    input  wire logic [XI_W-1:0]     i_x_index,
    input  wire logic [YI_W-1:0]     i_y_index,
    input  wire logic [ZI_W-1:0]     i_z_index,
    input  wire logic signed [31:0]  i_write_value,
    input  wire logic signed [31:0]  i_query_x,
    input  wire logic signed [31:0]  i_query_y,
    input  wire logic signed [31:0]  i_query_z,
    output logic                     o_push,
    output t_item                    o_item,
    input  wire logic                i_full
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  n_known;
    logic  w_take;

    assign o_ready = !r_valid || !i_full;
    assign w_take  = i_valid && o_ready;
    assign o_push  = r_valid && !i_full;
    assign o_item  = r_item;

    always_comb begin
        n_known          = 1'b1;
        n_item.op        = OP_WPT;
        n_item.pt_addr   = PT_AW'(X_BASE) + PT_AW'(i_x_index);
        n_item.grid_addr = {i_z_index, i_y_index, i_x_index};
        n_item.value     = i_write_value;
        n_item.qx        = i_query_x;
        n_item.qy        = i_query_y;
        n_item.qz        = i_query_z;
        case (i_req_type)
            REQ_WX: begin
            end
            REQ_WY: begin
                n_item.pt_addr = PT_AW'(Y_BASE) + PT_AW'(i_y_index);
            end
            REQ_WZ: begin
                n_item.pt_addr = PT_AW'(Z_BASE) + PT_AW'(i_z_index);
            end
            REQ_WGRID: begin
                n_item.op = OP_WGRID;
            end
            REQ_QUERY: begin
                n_item.op = OP_QUERY;
            end
            default: begin
                n_known = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= n_known;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/tti_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tti_fifo
// Small item queue between the input stage and the execution engine.
// ----------------------------------------------------------------------------
module tti_fifo
    import tti_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  t_item      i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output t_item      o_item,
    output logic       o_empty
);

    t_item                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr;
    logic [FIFO_AW-1:0]   r_rd;
    logic [FIFO_AW:0]     r_cnt;

    assign o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push)
                r_wr <= r_wr + FIFO_AW'(1);
            if (i_pop)
                r_rd <= r_rd + FIFO_AW'(1);
            if (i_push && !i_pop)
                r_cnt <= r_cnt + (FIFO_AW+1)'(1);
            else if (!i_push && i_pop)
                r_cnt <= r_cnt - (FIFO_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/tti_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tti_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tti_div
    import tti_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [DEN_W-1:0]  i_den,
    output logic                   o_done,
    output logic [NUM_W-1:0]       o_quo
);

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [NUM_W-1:0]  r_quo;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W:0]    w_trial;
    logic              w_ge;

    assign w_trial = {r_rem, r_quo[NUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign o_done  = r_done;
    assign o_quo   = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(NUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? DEN_W'(w_trial - {1'b0, r_den}) : w_trial[DEN_W-1:0];
        end
    end

endmodule
`default_nettype wire

// ----- hdl/tti_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tti_back
// Execution engine: breakpoint and grid storage, per-axis linear search,
// corner fetch and the seven interpolation steps, plus the output register.
// ----------------------------------------------------------------------------
module tti_back
    import tti_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_empty,
    input  t_item                    i_item,
    output logic                     o_pop,
    input  t_counts                  i_counts,
    output logic                     o_valid,
    output logic signed [31:0]       o_interp_value,
    input  wire logic                i_ready
);

    logic signed [31:0] r_pt_mem   [PT_DEPTH];
    logic signed [31:0] r_grid_mem [GRID_DEPTH];
    logic signed [31:0] r_pt_rd;
    logic signed [31:0] r_grid_rd;

    t_bstate r_state, n_state;

    logic signed [31:0] r_qx, r_qy, r_qz;
    logic [1:0]         r_ax;
    logic [CNT_W-1:0]   r_k;
    logic signed [31:0] r_prev;
    logic [CNT_W-1:0]   r_lo_i [3];
    logic [CNT_W-1:0]   r_hi_i [3];
    logic               r_clamp [3];
    logic signed [31:0] r_pl [3];
    logic signed [31:0] r_pu [3];
    logic signed [31:0] r_corner [8];
    logic [2:0]         r_cc;
    logic [2:0]         r_step;
    logic signed [31:0] r_lo, r_hi, r_q;
    logic signed [32:0] r_du, r_dv, r_dl;
    logic [DEN_W-1:0]   r_mdu, r_mdv;
    logic [49:0]        r_acc;
    logic [48:0]        r_acc_hi;
    logic [NUM_W-1:0]   r_num;
    logic               r_neg;
    logic               r_ovalid;
    logic signed [31:0] r_odata;

    logic [PT_AW-1:0]   w_pt_raddr;
    logic [GRID_AW-1:0] w_grid_raddr;
    logic [PT_AW-1:0]   w_base;
    logic [CNT_W-1:0]   w_n;
    logic [CNT_W-1:0]   w_nm1;
    logic signed [31:0] w_p;
    logic [1:0]         w_lax;
    logic [2:0]         w_lo_idx, w_hi_idx, w_c_idx;
    logic signed [31:0] w_c;
    logic signed [31:0] w_lp;
    logic [DEN_W-1:0]   w_mdl;
    logic               w_div_start;
    logic               w_div_done;
    logic [NUM_W-1:0]   w_quo;
    logic               w_ax_last;
    logic               w_out_load;
    logic signed [31:0] w_qsat;
    logic               w_big_neg, w_big_pos;

    assign o_pop          = (r_state == B_IDLE) && !i_empty;
    assign o_valid        = r_ovalid;
    assign o_interp_value = r_odata;
    assign w_ax_last      = (r_ax == 2'd2);
    assign w_out_load     = (r_state == B_DONE) && (!r_ovalid || i_ready);
    assign w_nm1          = w_n - CNT_W'(1);

    always_comb begin
        case (r_ax)
            2'd0: begin
                w_base = PT_AW'(X_BASE);
                w_n    = i_counts.x_n;
                w_p    = r_qx;
            end
            2'd1: begin
                w_base = PT_AW'(Y_BASE);
                w_n    = i_counts.y_n;
                w_p    = r_qy;
            end
            default: begin
                w_base = PT_AW'(Z_BASE);
                w_n    = i_counts.z_n;
                w_p    = r_qz;
            end
        endcase
    end

    always_comb begin
        if (r_step < 3'd4) begin
            w_lax    = 2'd0;
            w_lo_idx = {r_step[1:0], 1'b0};
            w_hi_idx = {r_step[1:0], 1'b1};
            w_lp     = r_qx;
        end else if (r_step < 3'd6) begin
            w_lax    = 2'd1;
            w_lo_idx = {r_step[0], 2'b00};
            w_hi_idx = {r_step[0], 2'b10};
            w_lp     = r_qy;
        end else begin
            w_lax    = 2'd2;
            w_lo_idx = 3'd0;
            w_hi_idx = 3'd4;
            w_lp     = r_qz;
        end
    end

    assign w_c_idx = (r_state == B_LCHK) ? w_lo_idx : w_hi_idx;
    assign w_c     = r_corner[w_c_idx];
    assign w_mdl   = r_dl[32] ? DEN_W'(-r_dl) : DEN_W'(r_dl);

    assign w_big_neg = (|w_quo[NUM_W-1:32]) || (w_quo[31] && (|w_quo[30:0]));
    assign w_big_pos = |w_quo[NUM_W-1:31];

    always_comb begin
        if (r_neg)
            w_qsat = w_big_neg ? 32'sh8000_0000 : -$signed(w_quo[31:0]);
        else
            w_qsat = w_big_pos ? 32'sh7fff_ffff : $signed(w_quo[31:0]);
    end

    always_comb begin
        n_state      = r_state;
        w_pt_raddr   = w_base;
        w_grid_raddr = {r_cc[2] ? r_hi_i[2][ZI_W-1:0] : r_lo_i[2][ZI_W-1:0],
                        r_cc[1] ? r_hi_i[1][YI_W-1:0] : r_lo_i[1][YI_W-1:0],
                        r_cc[0] ? r_hi_i[0][XI_W-1:0] : r_lo_i[0][XI_W-1:0]};
        w_div_start  = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (o_pop && i_item.op == OP_QUERY)
                    n_state = B_SRD0;
            end
            B_SRD0: begin
                n_state = B_SCHK0;
            end
            B_SCHK0: begin
                w_pt_raddr = w_base + PT_AW'(w_nm1);
                if (w_p <= r_pt_rd)
                    n_state = w_ax_last ? B_GISS : B_SRD0;
                else
                    n_state = B_SCHKN;
            end
            B_SCHKN: begin
                w_pt_raddr = w_base + PT_AW'(1);
                if (w_p >= r_pt_rd)
                    n_state = w_ax_last ? B_GISS : B_SRD0;
                else
                    n_state = B_SCAN;
            end
            B_SCAN: begin
                w_pt_raddr = w_base + PT_AW'(r_k) + PT_AW'(1);
                if (!(r_k < w_nm1 && r_pt_rd <= w_p))
                    n_state = w_ax_last ? B_GISS : B_SRD0;
            end
            B_GISS: begin
                n_state = B_GCAP;
            end
            B_GCAP: begin
                n_state = (r_cc == 3'd7) ? B_LCHK : B_GISS;
            end
            B_LCHK: begin
                if (!r_clamp[w_lax])
                    n_state = B_LHI;
                else if (r_step == 3'd6)
                    n_state = B_DONE;
            end
            B_LHI:  n_state = B_LM0;
            B_LM0:  n_state = B_LM1;
            B_LM1:  n_state = B_LM2;
            B_LM2:  n_state = B_LDIV;
            B_LDIV: begin
                if (r_num == '0 || r_dl == '0) begin
                    n_state = B_LWB;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = B_LWAIT;
                end
            end
            B_LWAIT: begin
                if (w_div_done)
                    n_state = B_LWB;
            end
            B_LWB: begin
                n_state = (r_step == 3'd6) ? B_DONE : B_LCHK;
            end
            B_DONE: begin
                if (w_out_load)
                    n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= B_IDLE;
        else
            r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.op == OP_WPT)
            r_pt_mem[i_item.pt_addr] <= i_item.value;
        r_pt_rd <= r_pt_mem[w_pt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.op == OP_WGRID)
            r_grid_mem[i_item.grid_addr] <= i_item.value;
        r_grid_rd <= r_grid_mem[w_grid_raddr];
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_qx <= i_item.qx;
                r_qy <= i_item.qy;
                r_qz <= i_item.qz;
                r_ax <= 2'd0;
                r_cc <= 3'd0;
            end
            B_SCHK0: begin
                r_prev <= r_pt_rd;
                if (w_p <= r_pt_rd) begin
                    r_lo_i[r_ax]  <= '0;
                    r_hi_i[r_ax]  <= '0;
                    r_clamp[r_ax] <= 1'b1;
                    r_ax          <= r_ax + 2'd1;
                end
            end
            B_SCHKN: begin
                r_k <= CNT_W'(1);
                if (w_p >= r_pt_rd) begin
                    r_lo_i[r_ax]  <= w_nm1;
                    r_hi_i[r_ax]  <= w_nm1;
                    r_clamp[r_ax] <= 1'b1;
                    r_ax          <= r_ax + 2'd1;
                end
            end
            B_SCAN: begin
                if (r_k < w_nm1 && r_pt_rd <= w_p) begin
                    r_prev <= r_pt_rd;
                    r_k    <= r_k + CNT_W'(1);
                end else begin
                    r_lo_i[r_ax]  <= r_k - CNT_W'(1);
                    r_hi_i[r_ax]  <= r_k;
                    r_clamp[r_ax] <= 1'b0;
                    r_pl[r_ax]    <= r_prev;
                    r_pu[r_ax]    <= r_pt_rd;
                    r_ax          <= r_ax + 2'd1;
                end
                r_cc <= 3'd0;
            end
            B_GCAP: begin
                r_corner[r_cc] <= r_grid_rd;
                r_cc           <= r_cc + 3'd1;
                r_step         <= 3'd0;
            end
            B_LCHK: begin
                r_lo <= w_c;
                if (r_clamp[w_lax] && r_step != 3'd6)
                    r_step <= r_step + 3'd1;
            end
            B_LHI: begin
                r_hi <= w_c;
                r_du <= 33'(r_pu[w_lax]) - 33'(w_lp);
                r_dv <= 33'(w_c) - 33'(r_lo);
                r_dl <= 33'(r_pu[w_lax]) - 33'(r_pl[w_lax]);
            end
            B_LM0: begin
                r_mdu <= r_du[32] ? DEN_W'(-r_du) : DEN_W'(r_du);
                r_mdv <= r_dv[32] ? DEN_W'(-r_dv) : DEN_W'(r_dv);
                r_neg <= r_du[32] != r_dv[32];
            end
            B_LM1: begin
                r_acc    <= r_mdu * r_mdv[16:0];
                r_acc_hi <= r_mdu * r_mdv[32:17];
            end
            B_LM2: begin
                r_num <= NUM_W'(r_acc) + (NUM_W'(r_acc_hi) << 17);
            end
            B_LDIV: begin
                if (r_num == '0)
                    r_q <= '0;
                else if (r_dl == '0)
                    r_q <= r_neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
                else
                    r_neg <= r_neg ^ r_dl[32];
            end
            B_LWAIT: begin
                if (w_div_done)
                    r_q <= w_qsat;
            end
            B_LWB: begin
                r_corner[w_lo_idx] <= sat33(33'(r_hi) - 33'(r_q));
                if (r_step != 3'd6)
                    r_step <= r_step + 3'd1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load)
            r_odata <= r_corner[0];
    end

    tti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num),
        .i_den   (w_mdl),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

endmodule
`default_nettype wire

// ----- hdl/trilinear_table_interpolator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// trilinear_table_interpolator
// Q16.16 trilinear lookup table with clamped axes and saturating division.
// ----------------------------------------------------------------------------
// Breakpoint and grid writes are stored by the execution engine as they are
// popped from the queue; a query runs a linear search over the breakpoints in
// use on each axis, eight corner reads and up to seven interpolated steps.
// Query time is set by the linear scan over the single-port breakpoint memory
// and by the bit-serial 66/33 divider. A four-entry queue and an output
// register let input and output handshakes proceed while a query is in
// progress. Table contents are undefined until written; no clearing pass runs
// after reset.
module trilinear_table_interpolator
    import tti_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [CNT_W-1:0]    i_cfg_data,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [2:0]          i_req_type,
    input  wire logic [XI_W-1:0]     i_x_index,
    input  wire logic [YI_W-1:0]     i_y_index,
    input  wire logic [ZI_W-1:0]     i_z_index,
    input  wire logic signed [31:0]  i_write_value,
    input  wire logic signed [31:0]  i_query_x,
    input  wire logic signed [31:0]  i_query_y,
    input  wire logic signed [31:0]  i_query_z,
    output logic                     o_valid,
    output logic signed [31:0]       o_interp_value,
    input  wire logic                i_ready
);

    logic [CNT_W-1:0]  r_x_cnt;
    logic [CNT_W-1:0]  r_y_cnt;
    logic [ZCNT_W-1:0] r_z_cnt;
    t_counts           w_counts;
    logic              w_push, w_full, w_pop, w_empty;
    t_item             w_front_item, w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_cnt <= CNT_W'(X_POINTS);
            r_y_cnt <= CNT_W'(Y_POINTS);
            r_z_cnt <= ZCNT_W'(Z_POINTS);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_X:   r_x_cnt <= i_cfg_data;
                CFG_Y:   r_y_cnt <= i_cfg_data;
                CFG_Z:   r_z_cnt <= i_cfg_data[ZCNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_counts.x_n = eff_count(r_x_cnt, X_POINTS);
    assign w_counts.y_n = eff_count(r_y_cnt, Y_POINTS);
    assign w_counts.z_n = eff_count(CNT_W'(r_z_cnt), Z_POINTS);

    tti_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_x_index     (i_x_index),
        .i_y_index     (i_y_index),
        .i_z_index     (i_z_index),
        .i_write_value (i_write_value),
        .i_query_x     (i_query_x),
        .i_query_y     (i_query_y),
        .i_query_z     (i_query_z),
        .o_push        (w_push),
        .o_item        (w_front_item),
        .i_full        (w_full)
    );

    tti_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_item  (w_head),
        .o_empty (w_empty)
    );

    tti_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (w_empty),
        .i_item         (w_head),
        .o_pop          (w_pop),
        .i_counts       (w_counts),
        .o_valid        (o_valid),
        .o_interp_value (o_interp_value),
        .i_ready        (i_ready)
    );

endmodule
`default_nettype wire

// ----- hdl/tti_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tti_checker
// Port-level checks of the interpolator: reset, output hold, result count.
// ----------------------------------------------------------------------------
module tti_checker
    import tti_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic                o_ready,
    input  wire logic [2:0]          i_req_type,
    input  wire logic                o_valid,
    input  wire logic signed [31:0]  o_interp_value,
    input  wire logic                i_ready
);

    localparam int PEND_MAX = FIFO_DEPTH + 3;
    localparam int PEND_W   = $clog2(PEND_MAX + 2);

    logic [PEND_W-1:0] r_pend;
    logic              w_qin, w_out;

    assign w_qin = i_valid && o_ready && (i_req_type == REQ_QUERY);
    assign w_out = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_pend <= '0;
        else if (w_qin && !w_out)
            r_pend <= r_pend + PEND_W'(1);
        else if (!w_qin && w_out)
            r_pend <= r_pend - PEND_W'(1);
    end

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_interp_value))
        else $error("stalled result changed");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_pend != '0)
        else $error("result without outstanding query");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= PEND_W'(PEND_MAX))
        else $error("too many outstanding queries");

endmodule

bind trilinear_table_interpolator tti_checker u_tti_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .i_req_type     (i_req_type),
    .o_valid        (o_valid),
    .o_interp_value (o_interp_value),
    .i_ready        (i_ready)
);
`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trilinear table interpolator testbench
// Loads breakpoint axes and sub-grids for several count settings, then fires
// queries at them. A directed table covers extremes and clamping, random
// phases follow. Each result is checked against an in-bench predictor or a directed expected value.
// ----------------------------------------------------------------------------
module testbench;
    import tti_pkg::*;

    localparam logic [2:0] REQ_BAD_LO = 3'd5;
    localparam logic [2:0] REQ_BAD_HI = 3'd7;
    localparam int         CYCLE_CAP  = 4000000;
    localparam int         ITEM_GOAL  = 1050;

    typedef struct {
        logic [2:0]         req;
        logic [6:0]         xi;
        logic [6:0]         yi;
        logic [4:0]         zi;
        logic signed [31:0] wv;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        logic signed [31:0] qz;
        bit                 chk;
        logic signed [31:0] expv;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [1:0]         i_cfg_index;
    logic [CNT_W-1:0]   i_cfg_data;
    logic               i_valid;
    logic               o_ready;
    logic [2:0]         i_req_type;
    logic [XI_W-1:0]    i_x_index;
    logic [YI_W-1:0]    i_y_index;
    logic [ZI_W-1:0]    i_z_index;
    logic signed [31:0] i_write_value;
    logic signed [31:0] i_query_x;
    logic signed [31:0] i_query_y;
    logic signed [31:0] i_query_z;
    logic               o_valid;
    logic signed [31:0] o_interp_value;
    logic               i_ready;

    trilinear_table_interpolator dut (.*);

    // predictor state
    logic signed [31:0] pts [PT_DEPTH];
    logic signed [31:0] gv [int];
    logic [7:0]         cnt_x, cnt_y, cnt_z;
    logic signed [31:0] interp_q [$];

    int  errors = 0;
    int  n_items = 0;
    int  cycles = 0;
    int  tx_idle = 26;
    int  rx_idle = 69;
    bit  rx_hold = 0;
    t_row dir_tab [22];

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic mismatch(input string msg);
        $display("MISMATCH @%0d: %s", cycles, msg);
        errors++;
    endtask

    function automatic int used(input logic [7:0] r, input int size);
        if (r == 0) return 1;
        if (int'(r) > size) return size;
        return int'(r);
    endfunction

    function automatic int gkey(input int z, input int y, input int x);
        return z * 16384 + y * 128 + x;
    endfunction

    function automatic logic signed [31:0] grid_at(input int z, input int y, input int x);
        int k;
        k = gkey(z, y, x);
        return gv.exists(k) ? gv[k] : 32'sd0;
    endfunction

    function automatic logic signed [31:0] blend(input logic signed [31:0] hi,
            input logic signed [31:0] lo, input logic signed [31:0] u,
            input logic signed [31:0] p, input logic signed [31:0] l);
        logic signed [32:0] du, dv, dl, r;
        logic [32:0]        mu, mv, ml;
        logic [65:0]        num, m;
        bit                 neg;
        logic signed [31:0] q;
        du = {u[31], u} - {p[31], p};
        dv = {hi[31], hi} - {lo[31], lo};
        dl = {u[31], u} - {l[31], l};
        neg = (du < 0) != (dv < 0);
        mu = du[32] ? 33'(-du) : 33'(du);
        mv = dv[32] ? 33'(-dv) : 33'(dv);
        ml = dl[32] ? 33'(-dl) : 33'(dl);
        num = 66'(mu) * 66'(mv);
        if (num == 0) begin
            q = 0;
        end else if (dl == 0) begin
            q = neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            m = num / 66'(ml);
            if (dl < 0) neg = !neg;
            if (neg) q = (m > 66'h8000_0000) ? 32'sh8000_0000 : -$signed(m[31:0]);
            else     q = (m > 66'h7fff_ffff) ? 32'sh7fff_ffff : $signed(m[31:0]);
        end
        r = {hi[31], hi} - {q[31], q};
        if (r > 33'sh0_7fff_ffff) return 32'sh7fff_ffff;
        if (r < -33'sh0_8000_0000) return 32'sh8000_0000;
        return r[31:0];
    endfunction

    function automatic bit locate(input int base, input int n,
            input logic signed [31:0] p, output int lo, output int hi);
        int k;
        if (p <= pts[base]) begin
            lo = 0; hi = 0; return 1;
        end
        if (p >= pts[base + n - 1]) begin
            lo = n - 1; hi = n - 1; return 1;
        end
        k = 1;
        while (k < n - 1 && pts[base + k] <= p) k++;
        lo = k - 1;
        hi = k;
        return 0;
    endfunction

    function automatic logic signed [31:0] interp(input logic signed [31:0] px,
            input logic signed [31:0] py, input logic signed [31:0] pz);
        int xl, xu, yl, yu, zl, zu;
        bit xs, ys, zs;
        logic signed [31:0] c [2][2][2];
        zs = locate(Z_BASE, used(cnt_z, Z_POINTS), pz, zl, zu);
        ys = locate(Y_BASE, used(cnt_y, Y_POINTS), py, yl, yu);
        xs = locate(X_BASE, used(cnt_x, X_POINTS), px, xl, xu);
        for (int a = 0; a < 2; a++)
            for (int b = 0; b < 2; b++) begin
                c[a][b][0] = grid_at(a ? zu : zl, b ? yu : yl, xl);
                c[a][b][1] = grid_at(a ? zu : zl, b ? yu : yl, xu);
            end
        for (int a = 0; a < 2; a++)
            for (int b = 0; b < 2; b++)
                if (!xs) c[a][b][0] = blend(c[a][b][1], c[a][b][0],
                                            pts[X_BASE + xu], px, pts[X_BASE + xl]);
        for (int a = 0; a < 2; a++)
            if (!ys) c[a][0][0] = blend(c[a][1][0], c[a][0][0],
                                        pts[Y_BASE + yu], py, pts[Y_BASE + yl]);
        if (!zs) return blend(c[1][0][0], c[0][0][0], pts[Z_BASE + zu], pz, pts[Z_BASE + zl]);
        return c[0][0][0];
    endfunction

    // one input transaction; expectation pushed at acceptance
    task automatic put(input logic [2:0] req, input int xi, input int yi, input int zi,
            input logic signed [31:0] wv, input logic signed [31:0] qx,
            input logic signed [31:0] qy, input logic signed [31:0] qz,
            input bit chk, input logic signed [31:0] expv);
        logic signed [31:0] v;
        if ($urandom_range(0, 99) < tx_idle) begin
            i_valid <= 0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < tx_idle);
        end
        i_valid       <= 1;
        i_req_type    <= req;
        i_x_index     <= XI_W'(xi);
        i_y_index     <= YI_W'(yi);
        i_z_index     <= ZI_W'(zi);
        i_write_value <= wv;
        i_query_x     <= qx;
        i_query_y     <= qy;
        i_query_z     <= qz;
        do @(posedge i_clk); while (!o_ready);
        case (req)
            REQ_WX:    pts[X_BASE + xi] = wv;
            REQ_WY:    pts[Y_BASE + yi] = wv;
            REQ_WZ:    pts[Z_BASE + zi] = wv;
            REQ_WGRID: gv[gkey(zi, yi, xi)] = wv;
            REQ_QUERY: begin
                v = interp(qx, qy, qz);
                interp_q.push_back(chk ? expv : v);
            end
            default: ;
        endcase
        if (req <= REQ_QUERY) n_items++;
        tx_idle = n_items < 350 ? 26 : (n_items < 700 ? 69 : 0);
        rx_idle = n_items < 350 ? 69 : (n_items < 700 ? 26 : 0);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (interp_q.size() != 0) @(negedge i_clk);
        repeat (64) @(negedge i_clk);
    endtask

    task automatic set_counts(input logic [7:0] nx, input logic [7:0] ny, input logic [7:0] nz);
        logic [1:0]  idx [3];
        logic [7:0]  val [3];
        idx = '{CFG_X, CFG_Y, CFG_Z};
        val = '{nx, ny, nz};
        for (int i = 0; i < 3; i++) begin
            i_cfg_wr_en <= 1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= val[i];
            @(negedge i_clk);
        end
        i_cfg_wr_en <= 0;
        cnt_x = nx;
        cnt_y = ny;
        cnt_z = nz & 8'h3f;
    endtask

    function automatic logic signed [31:0] rand_val();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            default: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
        endcase
    endfunction

    task automatic load_axis(input logic [2:0] req, input int n);
        longint v;
        bit     mono;
        mono = $urandom_range(0, 9) != 0;
        v = longint'($signed($urandom_range(0, 32'h0200_0000))) - 32'sh0100_0000;
        if ($urandom_range(0, 7) == 0) v = -64'sd2147483648;
        for (int k = 0; k < n; k++) begin
            put(req, k, k, k, mono ? 32'(v) : $urandom, 0, 0, 0, 0, 0);
            v += $urandom_range(1, $urandom_range(0, 1) ? 32'h0040_0000 : 32'h0002_0000);
        end
    endtask

    function automatic logic signed [31:0] pick(input int base, input int n);
        int     r, k;
        longint lo, hi;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, n - 1);
        lo = pts[base + k];
        hi = (k < n - 1) ? longint'(pts[base + k + 1]) : lo;
        if (r < 12) return $urandom;
        if (r < 20) return 32'sh8000_0000 + $urandom_range(0, 1) * 32'sh7fff_ffff;
        if (r < 32) begin
            lo = $urandom_range(0, 1)
                 ? longint'(pts[base]) - longint'($urandom_range(0, 5000))
                 : longint'(pts[base + n - 1]) + longint'($urandom_range(0, 5000));
            if (lo > 2147483647) lo = 2147483647;
            if (lo < -2147483648) lo = -2147483648;
            return 32'(lo);
        end
        if (r < 42 || hi <= lo) return pts[base + k];
        return 32'(lo + longint'($urandom) % (hi - lo));
    endfunction

    task automatic noise();
        case ($urandom_range(0, 4))
            0: put(REQ_WX, $urandom_range(0, 127), $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, 0, 0);
            1: put(REQ_WGRID, $urandom_range(0, 127), $urandom_range(0, 127),
                   $urandom_range(0, 31), $urandom, $urandom, $urandom, $urandom, 0, 0);
            default: put(3'($urandom_range(REQ_BAD_LO, REQ_BAD_HI)), $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom, $urandom, 0, 0);
        endcase
    endtask

    task automatic run_phase(input logic [7:0] rx, input logic [7:0] ry, input logic [7:0] rz);
        int nx, ny, nz, nq;
        drain();
        set_counts(rx, ry, rz);
        nx = used(cnt_x, X_POINTS);
        ny = used(cnt_y, Y_POINTS);
        nz = used(cnt_z, Z_POINTS);
        load_axis(REQ_WX, nx);
        load_axis(REQ_WY, ny);
        load_axis(REQ_WZ, nz);
        for (int z = 0; z < nz; z++)
            for (int y = 0; y < ny; y++)
                for (int x = 0; x < nx; x++)
                    put(REQ_WGRID, x, y, z, rand_val(), 0, 0, 0, 0, 0);
        nq = (nx * ny * nz > 64) ? 6 : $urandom_range(10, 30);
        for (int i = 0; i < nq; i++) begin
            if ($urandom_range(0, 4) == 0) noise();
            put(REQ_QUERY, $urandom, $urandom, $urandom, $urandom, pick(X_BASE, nx),
                pick(Y_BASE, ny), pick(Z_BASE, nz), 0, 0);
        end
    endtask

    // receiver
    initial begin
        i_ready = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                if (interp_q.size() == 0)
                    mismatch($sformatf("unexpected result %h", o_interp_value));
                else if (o_interp_value !== interp_q[0])
                    mismatch($sformatf("interp_value %h, want %h",
                                       o_interp_value, interp_q.pop_front()));
                else
                    void'(interp_q.pop_front());
            end
            @(negedge i_clk);
            i_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle);
        end
    end

    // long receiver hold-off to back up the input queue
    initial begin
        wait (n_items >= 300);
        rx_hold = 1;
        repeat (3000) @(posedge i_clk);
        rx_hold = 0;
    end

    initial begin
        dir_tab = '{
            '{REQ_WX,    0,   0, 0, 32'sh0000_0000, 0, 0, 0, 0, 0},
            '{REQ_WX,    1,   0, 0, 32'sh0001_0000, 0, 0, 0, 0, 0},
            '{REQ_WY,    0,   0, 0, 32'sh0000_0000, 0, 0, 0, 0, 0},
            '{REQ_WY,    0,   1, 0, 32'sh0001_0000, 0, 0, 0, 0, 0},
            '{REQ_WZ,    0,   0, 0, 32'sh0000_0000, 0, 0, 0, 0, 0},
            '{REQ_WZ,    0,   0, 1, 32'sh0001_0000, 0, 0, 0, 0, 0},
            '{REQ_WGRID, 0,   0, 0, 32'sh7fff_ffff, 0, 0, 0, 0, 0},
            '{REQ_WGRID, 1,   0, 0, 32'sh8000_0000, 0, 0, 0, 0, 0},
            '{REQ_WGRID, 0,   1, 0, 32'sh0000_0000, 0, 0, 0, 0, 0},
            '{REQ_WGRID, 1,   1, 0, 32'sh0001_0000, 0, 0, 0, 0, 0},
            '{REQ_WGRID, 0,   0, 1, -32'sd1,        0, 0, 0, 0, 0},
            '{REQ_WGRID, 1,   0, 1, 32'sd1,         0, 0, 0, 0, 0},
            '{REQ_WGRID, 0,   1, 1, 32'sh1234_5678, 0, 0, 0, 0, 0},
            '{REQ_WGRID, 1,   1, 1, 32'sh8000_0000, 0, 0, 0, 0, 0},
            '{REQ_WX,    127, 127, 31, 32'sh8000_0000, 0, 0, 0, 0, 0},
            '{REQ_QUERY, 0, 0, 0, 0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              1, 32'sh7fff_ffff},
            '{REQ_QUERY, 0, 0, 0, 0, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
              1, 32'sh8000_0000},
            '{REQ_QUERY, 0, 0, 0, 0, 32'sh0001_0000, 0, 32'sh0001_0000, 1, 32'sd1},
            '{REQ_QUERY, 0, 0, 0, 0, 32'sh0000_8000, 0, 0, 0, 0},
            '{REQ_BAD_LO, 127, 127, 31, 32'sh7fff_ffff, -1, -1, -1, 0, 0},
            '{REQ_BAD_HI, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{REQ_QUERY, 0, 0, 0, 0, 32'sh0000_4000, 32'sh0000_c000, 32'sh0000_2000, 0, 0}
        };
    end

    initial begin
        i_rst_n = 0;
        i_cfg_wr_en = 0;
        i_cfg_index = CFG_X;
        i_cfg_data = 0;
        i_valid = 0;
        i_req_type = REQ_WX;
        i_x_index = 0;
        i_y_index = 0;
        i_z_index = 0;
        i_write_value = 0;
        i_query_x = 0;
        i_query_y = 0;
        i_query_z = 0;
        cnt_x = 128;
        cnt_y = 128;
        cnt_z = 32;
        for (int i = 0; i < PT_DEPTH; i++) pts[i] = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        set_counts(2, 2, 2);
        foreach (dir_tab[i])
            put(dir_tab[i].req, dir_tab[i].xi, dir_tab[i].yi, dir_tab[i].zi, dir_tab[i].wv,
                dir_tab[i].qx, dir_tab[i].qy, dir_tab[i].qz, dir_tab[i].chk, dir_tab[i].expv);

        run_phase(0, 0, 0);
        run_phase(255, 1, 1);
        run_phase(1, 200, 1);
        run_phase(1, 1, 63);
        run_phase(128, 1, 2);
        run_phase(1, 2, 32);
        while (n_items < ITEM_GOAL)
            run_phase($urandom_range(1, 8), $urandom_range(1, 6), $urandom_range(1, 5));
        drain();

        if (errors == 0 && interp_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// ----- trilinear_table_interpolator.f -----
hdl/tti_pkg.sv
hdl/tti_front.sv
hdl/tti_fifo.sv
hdl/tti_div.sv
hdl/tti_back.sv
hdl/trilinear_table_interpolator.sv
hdl/tti_checker.sv
bench/testbench.sv
